// File: sv/levenshtein_distance_caseless_assert.svh
// Assertion macros used by the checker file of the edit distance block.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef LEVENSHTEIN_DISTANCE_CASELESS_ASSERT_SVH
`define LEVENSHTEIN_DISTANCE_CASELESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define LVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define LVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lvd_pkg.sv
// Package of the caseless edit distance block: widths, codes, FSM and bus types.
// No dependencies; every other file of the block but the assertion header imports it.
package lvd_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CH_W        = 8;
  localparam int DIST_W      = 7;

  // Item kinds on the input channel
  localparam logic REQ_COLUMN = 1'b0;
  localparam logic REQ_ROW    = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_SWEEP,
    S_RESULT
  } lvd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic prime;     // issue first read of a row sweep
    logic step;      // compute one cost row entry
    logic load_out;  // load the result register
  } lvd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_sweep;  // offered item is a row character that sweeps the row
    logic row_last;    // offered item is the last of a row string
    logic pend_last;   // sweeping item was the last of its row string
    logic sweep_done;  // current step is the last entry of the row
    logic out_free;    // result register can take a new result
  } lvd_sts_t;

endpackage

// File: sv/lvd_if.sv
// Valid/ready channel interfaces for the caseless edit distance block.
// Depends on lvd_pkg for field widths.
interface lvd_in_if;
  import lvd_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] ch;
  logic            last;
  logic            empty_req;

  modport source (output valid, req_type, ch, last, empty_req, input ready);
  modport sink   (input valid, req_type, ch, last, empty_req, output ready);
endinterface

interface lvd_out_if;
  import lvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              too_long;

  modport source (output valid, distance, too_long, input ready);
  modport sink   (input valid, distance, too_long, output ready);
endinterface

// File: sv/lvd_ctrl.sv
// Controller of the edit distance block: accept, row sweep and result sequencing.
// Depends on lvd_pkg for the state enum and the command/status structs.
module lvd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lvd_pkg::lvd_sts_t sts_i,
  output lvd_pkg::lvd_cmd_t cmd_o
);
  import lvd_pkg::*;

  lvd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.need_sweep) begin
            state_d = S_PRIME;
          end else if (sts_i.row_last) begin
            state_d = S_RESULT;
          end
        end
      end
      S_PRIME: begin
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = sts_i.pend_last ? S_RESULT : S_IDLE;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prime    = (state_q == S_PRIME);
    cmd_o.step     = (state_q == S_SWEEP);
    cmd_o.load_out = (state_q == S_RESULT) && sts_i.out_free;
  end

endmodule

// File: sv/lvd_dp.sv
// Datapath of the edit distance block: column store, cost row memory,
// one-entry-per-cycle row sweep and the result register. Depends on lvd_pkg.
module lvd_dp #(
  parameter int MAX_LEN = lvd_pkg::MAX_LEN_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lvd_pkg::lvd_cmd_t         cmd_i,
  output lvd_pkg::lvd_sts_t         sts_o,
  input  logic                      req_type_i,
  input  logic [lvd_pkg::CH_W-1:0]  ch_i,
  input  logic                      last_i,
  input  logic                      empty_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lvd_pkg::DIST_W-1:0] distance_o,
  output logic                      too_long_o
);
  import lvd_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);               // lengths, indexes, costs
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Fold a-z onto A-Z
  function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // Memories: column characters, and cost row entries 1..n (entry 0 is row_idx)
  logic [CH_W-1:0] col_mem  [MAX_LEN];
  logic [LW-1:0]   cost_mem [MAX_LEN];
  logic [CH_W-1:0] col_rd_q;
  logic [LW-1:0]   cost_rd_q;

  // Control registers
  logic          col_open_q, col_open_d;
  logic          col_over_q, col_over_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] col_len_q, col_len_d;
  logic [LW-1:0] row_idx_q, row_idx_d;
  logic          out_valid_q, out_valid_d;

  // Sweep registers
  logic [CH_W-1:0]   row_ch_q;
  logic              pend_last_q;
  logic [AW-1:0]     j_q;
  logic [LW-1:0]     corner_q;
  logic [LW-1:0]     left_q;
  logic [LW-1:0]     last_q;
  logic [DIST_W-1:0] dist_q;
  logic              too_long_q;

  logic          is_row, col_start, len_room, row_room, col_we, match, sweep_done;
  logic [LW-1:0] eff_len, eff_row, upper, min_uc, min_all, new_val, dist_full;
  logic [AW-1:0] rd_addr;

  // Item decode
  always_comb begin
    is_row    = (req_type_i == REQ_ROW);
    col_start = !col_open_q;
    eff_len   = col_start ? '0 : col_len_q;
    eff_row   = col_open_q ? '0 : row_idx_q;
    len_room  = eff_len < LW'(MAX_LEN);
    row_room  = eff_row < LW'(MAX_LEN);
    col_we    = cmd_i.accept && !is_row && !empty_req_i && len_room;
  end

  // One cost row entry: match takes the corner, else 1 + min of three neighbors
  always_comb begin
    upper      = (row_idx_q == '0) ? (LW'(j_q) + LW'(1)) : cost_rd_q;
    min_uc     = (upper < corner_q) ? upper : corner_q;
    min_all    = (left_q < min_uc) ? left_q : min_uc;
    match      = (row_ch_q == col_rd_q);
    new_val    = match ? corner_q : (min_all + LW'(1));
    sweep_done = (LW'(j_q) == (col_len_q - LW'(1)));
    rd_addr    = cmd_i.prime ? '0 : (j_q + AW'(1));
  end

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[eff_len[AW-1:0]] <= fold_case(ch_i);
    end
    if (cmd_i.step) begin
      cost_mem[j_q] <= new_val;
    end
    col_rd_q  <= col_mem[rd_addr];
    cost_rd_q <= cost_mem[rd_addr];
  end

  // Control next values
  always_comb begin
    col_open_d = col_open_q;
    col_over_d = col_over_q;
    ovf_d      = ovf_q;
    col_len_d  = col_len_q;
    row_idx_d  = row_idx_q;
    if (cmd_i.accept) begin
      if (!is_row) begin
        if (col_start) begin
          col_over_d = 1'b0;
          ovf_d      = 1'b0;
        end
        row_idx_d = '0;
        col_len_d = eff_len;
        if (!empty_req_i) begin
          if (len_room) begin
            col_len_d = eff_len + LW'(1);
          end else begin
            col_over_d = 1'b1;
            ovf_d      = 1'b1;
          end
        end
        col_open_d = !last_i;
      end else begin
        // a row item closes any open column string
        col_open_d = 1'b0;
        row_idx_d  = eff_row;
        if (!empty_req_i) begin
          if (!row_room) begin
            ovf_d = 1'b1;
          end else if (col_len_q == '0) begin
            row_idx_d = eff_row + LW'(1);
          end
        end
      end
    end
    if (cmd_i.step && sweep_done) begin
      row_idx_d = row_idx_q + LW'(1);
    end
    // after a result the row restarts against the same column
    if (cmd_i.load_out) begin
      row_idx_d = '0;
      ovf_d     = col_over_q;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_open_q  <= 1'b0;
      col_over_q  <= 1'b0;
      ovf_q       <= 1'b0;
      col_len_q   <= '0;
      row_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_open_q  <= col_open_d;
      col_over_q  <= col_over_d;
      ovf_q       <= ovf_d;
      col_len_q   <= col_len_d;
      row_idx_q   <= row_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Entry n of the cost row: n before any sweep, row_idx for an empty column
  always_comb begin
    if (col_len_q == '0) begin
      dist_full = row_idx_q;
    end else if (row_idx_q == '0) begin
      dist_full = col_len_q;
    end else begin
      dist_full = last_q;
    end
  end

  // Sweep and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_ch_q    <= fold_case(ch_i);
      pend_last_q <= last_i;
    end
    if (cmd_i.prime) begin
      j_q      <= '0;
      corner_q <= row_idx_q;
      left_q   <= row_idx_q + LW'(1);
    end
    if (cmd_i.step) begin
      j_q      <= j_q + AW'(1);
      corner_q <= upper;
      left_q   <= new_val;
      if (sweep_done) begin
        last_q <= new_val;
      end
    end
    if (cmd_i.load_out) begin
      dist_q     <= ovf_q ? '0 : DIST_W'(dist_full);
      too_long_q <= ovf_q;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.need_sweep = is_row && !empty_req_i && row_room && (col_len_q != '0);
    sts_o.row_last   = is_row && last_i;
    sts_o.pend_last  = pend_last_q;
    sts_o.sweep_done = sweep_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign too_long_o  = too_long_q;

endmodule

// File: sv/levenshtein_distance_caseless.sv
// Channel  | Dir | Payload                          | Accepted when
// in_i     | in  | req_type, ch, last, empty_req    | in_i.valid && in_i.ready
// out_o    | out | distance, too_long               | out_o.valid && out_o.ready
//
// A column item or a character-less item is taken in the idle state. A row
// character for a stored column of n >= 1 characters goes through the prime
// state, then the cost row is swept one entry per cycle through a single-port
// read of the cost row and column memories. Against an empty column, or past
// the row length limit, a row character is taken in the idle state alone. A
// row-last item adds a result load, held back while the result register is
// still held by a stall. Reset is asynchronous; no clearing pass is needed after it.
module levenshtein_distance_caseless #(
  parameter int MAX_LEN = lvd_pkg::MAX_LEN_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lvd_in_if.sink  in_i,
  lvd_out_if.source out_o
);
  import lvd_pkg::*;

  lvd_cmd_t cmd;
  lvd_sts_t sts;

  // Sequencing
  lvd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  lvd_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (in_i.req_type),
    .ch_i        (in_i.ch),
    .last_i      (in_i.last),
    .empty_req_i (in_i.empty_req),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .distance_o  (out_o.distance),
    .too_long_o  (out_o.too_long)
  );

endmodule

// File: sv/lvd_checker.sv
// Port-level checks of the edit distance block, bound to its top level.
// Depends on lvd_pkg and levenshtein_distance_caseless_assert.svh.
`include "levenshtein_distance_caseless_assert.svh"

module lvd_checker #(
  parameter int MAX_LEN = lvd_pkg::MAX_LEN_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_req_type_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lvd_pkg::DIST_W-1:0] distance_i,
  input logic                       too_long_i
);
  import lvd_pkg::*;

  // A stalled result holds
  `LVD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(distance_i) && $stable(too_long_i), "result changed while stalled")

  // An overflowed result reports distance zero
  `LVD_ASSERT_NOW(a_ovf_zero, out_valid_i && too_long_i, distance_i == '0, "too_long with nonzero distance")

  // A distance never exceeds the longest allowed string
  `LVD_ASSERT_NOW(a_dist_max, out_valid_i && !too_long_i, 32'(distance_i) <= 32'(MAX_LEN), "distance above MAX_LEN")

  // The last row item always leads to a busy cycle (sweep or result load)
  `LVD_ASSERT_NEXT(a_row_last_busy, in_valid_i && in_ready_i && (in_req_type_i == REQ_ROW) && in_last_i, !in_ready_i, "ready after last row item")

endmodule

bind levenshtein_distance_caseless lvd_checker #(
  .MAX_LEN (MAX_LEN)
) u_lvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.req_type),
  .in_last_i     (in_i.last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .distance_i    (out_o.distance),
  .too_long_i    (out_o.too_long)
);

// File: verif/levenshtein_distance_caseless_tb.sv
// Self-checking testbench for the caseless edit distance block.
// Drives string items on the input channel and checks every distance result
// against an in-bench dynamic-programming predictor. Needs lvd_pkg and lvd_if.
`timescale 1ns / 100ps

module levenshtein_distance_caseless_tb;
  import lvd_pkg::*;

  localparam int MAX_CHARS     = MAX_LEN_DEF;
  localparam int RANDOM_ITEMS  = 950;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] ch;
    logic            last;
    logic            empty_req;
  } str_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } dist_res_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TRICKLE} rx_mode_e;
  typedef enum int {ALPHA_ANY, ALPHA_FEW} alpha_e;
  typedef enum int {END_ON_CHAR, END_ON_EMPTY, END_OPEN} str_end_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  lvd_in_if  str_in ();
  lvd_out_if dist_out ();

  levenshtein_distance_caseless dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (str_in),
    .out_o  (dist_out)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus and expected results
  str_item_t pending_items[$];
  dist_res_t pending_dists[$];
  int        queued_total = 0;
  int        items_taken;
  int        results_seen = 0;
  int        mismatches = 0;

  // Predictor state
  bit [CH_W-1:0]   col_text [MAX_CHARS];
  bit [DIST_W-1:0] edit_row [MAX_CHARS+1];
  bit [DIST_W-1:0] col_len = '0;
  bit [DIST_W-1:0] rows_done = '0;
  bit              over_flag = 1'b0;
  bit              col_active = 1'b0;
  bit              col_too_long = 1'b0;

  function automatic bit [CH_W-1:0] upcase(bit [CH_W-1:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Cost row of the stored column string against an empty row string
  function automatic void init_cost_row();
    for (int k = 0; k <= col_len; k++) begin
      edit_row[k] = DIST_W'(k);
    end
    rows_done = '0;
  endfunction

  // One row character updates the whole cost row
  function automatic void sweep_char(bit [CH_W-1:0] c);
    bit [DIST_W-1:0] diag;
    bit [DIST_W-1:0] above;
    bit [DIST_W-1:0] lo;
    diag = rows_done;
    edit_row[0] = rows_done + 1'b1;
    for (int j = 0; j < col_len; j++) begin
      above = edit_row[j+1];
      if (c == col_text[j]) begin
        edit_row[j+1] = diag;
      end else begin
        lo = (above < diag) ? above : diag;
        if (edit_row[j] < lo) begin
          lo = edit_row[j];
        end
        edit_row[j+1] = lo + 1'b1;
      end
      diag = above;
    end
    rows_done = rows_done + 1'b1;
  endfunction

  function automatic void predict_item(str_item_t it);
    bit [CH_W-1:0] c;
    dist_res_t     res;
    c = upcase(it.ch);
    if (it.req_type == REQ_COLUMN) begin
      // first column item after a closed column starts a new string
      if (!col_active) begin
        col_active   = 1'b1;
        col_len      = '0;
        col_too_long = 1'b0;
        over_flag    = 1'b0;
        rows_done    = '0;
      end
      if (!it.empty_req) begin
        if (col_len < MAX_CHARS) begin
          col_text[col_len] = c;
          col_len = col_len + 1'b1;
        end else begin
          col_too_long = 1'b1;
          over_flag    = 1'b1;
        end
      end
      if (it.last) begin
        col_active = 1'b0;
        init_cost_row();
      end
    end else begin
      // a row item closes any open column string
      if (col_active) begin
        col_active = 1'b0;
        init_cost_row();
      end
      if (!it.empty_req) begin
        if (rows_done < MAX_CHARS) begin
          sweep_char(c);
        end else begin
          over_flag = 1'b1;
        end
      end
      if (it.last) begin
        res.too_long = over_flag;
        res.distance = over_flag ? '0 : edit_row[col_len];
        pending_dists = {pending_dists, res};
        init_cost_row();
        over_flag = col_too_long;
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_result(dist_res_t got);
    dist_res_t want;
    if (pending_dists.size() == 0) begin
      report_mismatch($sformatf("unexpected result distance %0d too_long %0b",
                                got.distance, got.too_long));
    end else begin
      want = pending_dists.pop_front();
      if (got.distance !== want.distance) begin
        report_mismatch($sformatf("distance %0d, expected %0d",
                                  got.distance, want.distance));
      end
      if (got.too_long !== want.too_long) begin
        report_mismatch($sformatf("too_long %0b, expected %0b",
                                  got.too_long, want.too_long));
      end
    end
    results_seen++;
  endtask

  // Sender: bursts of items with random gaps between them
  str_item_t offered;
  int        burst_left;
  int        gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_in.valid     <= 1'b0;
      str_in.req_type  <= REQ_COLUMN;
      str_in.ch        <= '0;
      str_in.last      <= 1'b0;
      str_in.empty_req <= 1'b0;
      offered          <= '0;
      items_taken      <= 0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else begin : drive
      str_item_t nx;
      if (str_in.valid && str_in.ready) begin
        predict_item(offered);
        items_taken <= items_taken + 1;
      end
      if (!str_in.valid || str_in.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          str_in.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nx = pending_items.pop_front();
          offered          <= nx;
          str_in.valid     <= 1'b1;
          str_in.req_type  <= nx.req_type;
          str_in.ch        <= nx.ch;
          str_in.last      <= nx.last;
          str_in.empty_req <= nx.empty_req;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          str_in.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering items
  int hold_left;
  int holds_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && items_taken >= 300 + 600 * holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: stall pattern switches among four randomly chosen modes
  rx_mode_e stall_mode;
  int       mode_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_out.ready <= 1'b0;
      stall_mode     <= RX_OPEN;
      mode_left      <= 0;
    end else begin
      if (dist_out.valid && dist_out.ready) begin
        check_result({dist_out.distance, dist_out.too_long});
      end
      if (mode_left == 0) begin
        stall_mode <= rx_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        dist_out.ready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN:    dist_out.ready <= 1'b1;
          RX_COIN:    dist_out.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  dist_out.ready <= ((mode_left % 4) == 0);
          default:    dist_out.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic push_item(logic kind, logic [CH_W-1:0] c, logic last, logic empty);
    str_item_t it;
    it.req_type  = kind;
    it.ch        = c;
    it.last      = last;
    it.empty_req = empty;
    pending_items = {pending_items, it};
    queued_total++;
  endtask

  function automatic logic [CH_W-1:0] pick_char(alpha_e alpha);
    logic [CH_W-1:0] c;
    if (alpha == ALPHA_ANY) begin
      return 8'($urandom);
    end
    // few letters in mixed case, so that matches are common
    c = 8'h41 + 8'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) begin
      c = c + 8'h20;
    end
    return c;
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(0, 6);
    end else if (r < 94) begin
      return $urandom_range(7, 24);
    end else if (r < 98) begin
      return $urandom_range(25, MAX_CHARS);
    end
    return $urandom_range(MAX_CHARS + 1, MAX_CHARS + 4);
  endfunction

  // One string with occasional stray character-less items inside it
  task automatic queue_string(logic kind, int len, alpha_e alpha, str_end_e how);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        push_item(kind, 8'($urandom), 1'b0, 1'b1);
      end
      push_item(kind, pick_char(alpha), (how == END_ON_CHAR) && (i == len - 1), 1'b0);
    end
    if (how == END_ON_EMPTY || (how == END_ON_CHAR && len == 0)) begin
      push_item(kind, 8'($urandom), 1'b1, 1'b1);
    end
  endtask

  initial begin
    int       target;
    int       kind_pick;
    int       n_rows;
    alpha_e   alpha;
    str_end_e col_end;
    str_end_e row_end;

    rst_ni = 1'b0;

    // Directed: row string before any column string
    push_item(REQ_ROW, 8'h78, 1'b1, 1'b0);
    // case folding at both ends of the lower-case range
    push_item(REQ_COLUMN, 8'h61, 1'b0, 1'b0);
    push_item(REQ_COLUMN, 8'h7A, 1'b1, 1'b0);
    push_item(REQ_ROW, 8'h41, 1'b0, 1'b0);
    push_item(REQ_ROW, 8'h7A, 1'b1, 1'b0);
    // same column again, then an empty row string
    push_item(REQ_ROW, 8'hFF, 1'b1, 1'b0);
    push_item(REQ_ROW, 8'h00, 1'b1, 1'b1);
    // byte extremes and neighbors of the letter ranges, empty flag mid-string
    push_item(REQ_COLUMN, 8'h00, 1'b0, 1'b0);
    push_item(REQ_COLUMN, 8'hFF, 1'b0, 1'b1);
    push_item(REQ_COLUMN, 8'hFF, 1'b0, 1'b0);
    push_item(REQ_COLUMN, 8'h60, 1'b0, 1'b0);
    push_item(REQ_COLUMN, 8'h7B, 1'b1, 1'b0);
    push_item(REQ_ROW, 8'h80, 1'b0, 1'b0);
    push_item(REQ_ROW, 8'h55, 1'b0, 1'b1);
    push_item(REQ_ROW, 8'h7B, 1'b1, 1'b0);
    // empty column string
    push_item(REQ_COLUMN, 8'h5B, 1'b1, 1'b1);
    push_item(REQ_ROW, 8'h71, 1'b1, 1'b0);
    // row item while the column string is still open
    push_item(REQ_COLUMN, 8'h6D, 1'b0, 1'b0);
    push_item(REQ_ROW, 8'h4D, 1'b1, 1'b0);
    // column ended by an empty item, rows ended the same way
    push_item(REQ_COLUMN, 8'h6B, 1'b0, 1'b0);
    push_item(REQ_COLUMN, 8'h40, 1'b1, 1'b1);
    push_item(REQ_ROW, 8'h40, 1'b1, 1'b1);
    push_item(REQ_ROW, 8'h6B, 1'b0, 1'b0);
    push_item(REQ_ROW, 8'h3F, 1'b1, 1'b1);

    // Full-length strings with no match: largest distance
    for (int i = 0; i < MAX_CHARS; i++) begin
      push_item(REQ_COLUMN, 8'h61, i == MAX_CHARS - 1, 1'b0);
    end
    for (int i = 0; i < MAX_CHARS; i++) begin
      push_item(REQ_ROW, (i % 2) ? 8'h42 : 8'h62, i == MAX_CHARS - 1, 1'b0);
    end
    // Column overflow, then row overflow
    queue_string(REQ_COLUMN, MAX_CHARS + 1 + $urandom_range(0, 2), ALPHA_FEW, END_ON_CHAR);
    queue_string(REQ_ROW, 3, ALPHA_FEW, END_ON_CHAR);
    queue_string(REQ_COLUMN, 5, ALPHA_FEW, END_ON_CHAR);
    queue_string(REQ_ROW, MAX_CHARS + 1 + $urandom_range(0, 1), ALPHA_FEW, END_ON_CHAR);

    // Random: mostly column plus row strings, some broken sequences
    target = queued_total + RANDOM_ITEMS;
    while (queued_total < target) begin
      kind_pick = $urandom_range(0, 19);
      alpha     = ($urandom_range(0, 9) < 6) ? ALPHA_FEW : ALPHA_ANY;
      if (kind_pick < 14) begin
        case ($urandom_range(0, 19))
          0, 1, 2: col_end = END_ON_EMPTY;
          3, 4, 5: col_end = END_OPEN;
          default: col_end = END_ON_CHAR;
        endcase
        queue_string(REQ_COLUMN, rand_len(), alpha, col_end);
        n_rows = $urandom_range(1, 3);
        for (int r = 0; r < n_rows; r++) begin
          row_end = ($urandom_range(0, 5) == 0) ? END_ON_EMPTY : END_ON_CHAR;
          queue_string(REQ_ROW, rand_len(), alpha, row_end);
        end
      end else if (kind_pick < 17) begin
        queue_string(REQ_ROW, rand_len(), alpha, END_ON_CHAR);
      end else if (kind_pick < 19) begin
        queue_string(REQ_COLUMN, rand_len(), alpha, END_ON_CHAR);
      end else begin
        push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b1);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_taken == queued_total);
    wait (pending_dists.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
